// ===== sv/fatlb_pkg.sv =====
// Shared types, constants and helpers for the fully associative TLB.
// Used by every module of the block; depends on nothing.
package fatlb_pkg;

  // Geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned FuncW   = 2;

  // Command queue between front and back
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Operation codes on the func port
  localparam logic [FuncW-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FuncW-1:0] FUNC_FILL   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_INVAL  = 2'd2;

  // Classified operation
  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_FILL,
    OP_INVAL,
    OP_NONE
  } op_e;

  // One classified command word
  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] vpn;
    logic [DataW-1:0] ppn;
    logic [DataW-1:0] now;
  } item_t;

  // One result word
  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] ppn;
    logic [SlotW-1:0] slot;
  } result_t;

  // Reduce an entry index to the slot field (low bits only)
  function automatic logic [SlotW-1:0] idx_to_slot(logic [IdxW-1:0] idx);
    logic [IdxW+SlotW-1:0] wide;
    wide = {{SlotW{1'b0}}, idx};
    return wide[SlotW-1:0];
  endfunction

endpackage

// ===== sv/fatlb_front.sv =====
// Front part of the TLB: decodes each incoming word and queues it for the back part.
// Depends on fatlb_pkg.
module fatlb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [fatlb_pkg::FuncW-1:0]   func_i,
  input  logic [fatlb_pkg::DataW-1:0]   vpn_i,
  input  logic [fatlb_pkg::DataW-1:0]   ppn_i,
  input  logic [fatlb_pkg::DataW-1:0]   now_cycle_i,
  output logic                          q_valid_o,
  input  logic                          q_pop_i,
  output fatlb_pkg::item_t              q_item_o
);
  import fatlb_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  item_t            new_item;
  logic             do_push, do_pop;

  // Classify the operation code
  always_comb begin
    new_item.vpn = vpn_i;
    new_item.ppn = ppn_i;
    new_item.now = now_cycle_i;
    case (func_i)
      FUNC_LOOKUP: new_item.op = OP_LOOKUP;
      FUNC_FILL:   new_item.op = OP_FILL;
      FUNC_INVAL:  new_item.op = OP_INVAL;
      default:     new_item.op = OP_NONE;
    endcase
  end

  // Queue handshake
  assign full      = (cnt_q == QCntW'(QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && q_valid_o;
  assign q_item_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ===== sv/fatlb_back.sv =====
// Back part of the TLB: entry storage, lookup, fill with LRU victim scan, invalidate,
// and the result register. Depends on fatlb_pkg.
module fatlb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  fatlb_pkg::item_t              q_item_i,
  output logic                          empty,
  input  logic                          pop,
  output fatlb_pkg::result_t            res_o
);
  import fatlb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FILL = 3'b100
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  // Entry storage
  logic [ENTRIES-1:0] valid_q;
  logic [DataW-1:0]   vpn_q      [ENTRIES];
  logic [DataW-1:0]   ppn_q      [ENTRIES];
  logic [DataW-1:0]   last_use_q [ENTRIES];

  // Sequencer state
  state_e           state_q, state_d;
  item_t            cur_q, cur_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  best_q, best_d;
  logic [DataW-1:0] best_time_q, best_time_d;

  // Result register
  logic    out_valid_q;
  result_t res_q, res_d;
  logic    res_we, out_free;

  // Per-entry compare results
  logic [ENTRIES-1:0] match, stale;
  logic               any_match, any_free;
  logic [IdxW-1:0]    hit_idx, free_idx;

  // Entry update controls
  logic             take;
  logic             touch_we, inval_we, fill_we;
  logic [IdxW-1:0]  fill_idx;
  item_t            fill_item;

  assign out_free = !out_valid_q || pop;
  assign take     = (state_q == ST_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = take;
  assign empty    = !out_valid_q;
  assign res_o    = res_q;

  // Compare the head word against every entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (vpn_q[i] == q_item_i.vpn);
      stale[i] = (ppn_q[i] == q_item_i.ppn);
    end
  end

  // Encode lowest match and lowest free entry
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
    any_match = |match;
    any_free  = ~&valid_q;
  end

  // Sequence each command
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    best_d      = best_q;
    best_time_d = best_time_q;
    res_we      = 1'b0;
    res_d       = '0;
    touch_we    = 1'b0;
    inval_we    = 1'b0;
    fill_we     = 1'b0;
    fill_idx    = free_idx;
    fill_item   = q_item_i;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (q_item_i.op)
            OP_LOOKUP: begin
              touch_we = 1'b1;
              res_we   = 1'b1;
              if (any_match) begin
                res_d.hit  = 1'b1;
                res_d.ppn  = ppn_q[hit_idx];
                res_d.slot = idx_to_slot(hit_idx);
              end
            end
            OP_FILL: begin
              if (any_free) begin
                fill_we    = 1'b1;
                res_we     = 1'b1;
                res_d.slot = idx_to_slot(free_idx);
              end else if (ENTRIES == 1) begin
                cur_d   = q_item_i;
                best_d  = '0;
                state_d = ST_FILL;
              end else begin
                cur_d       = q_item_i;
                best_d      = '0;
                best_time_d = last_use_q[0];
                idx_d       = IdxW'(1);
                state_d     = ST_SCAN;
              end
            end
            OP_INVAL: begin
              inval_we = 1'b1;
              res_we   = 1'b1;
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Keep the oldest entry seen so far; ties stay with the lower index
        if (last_use_q[idx_q] < best_time_q) begin
          best_d      = idx_q;
          best_time_d = last_use_q[idx_q];
        end
        if (idx_q == LastIdx) begin
          state_d = ST_FILL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FILL: begin
        if (out_free) begin
          fill_we    = 1'b1;
          fill_idx   = best_q;
          fill_item  = cur_q;
          res_we     = 1'b1;
          res_d.slot = idx_to_slot(best_q);
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold scan context and result word
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    idx_q       <= idx_d;
    best_q      <= best_d;
    best_time_q <= best_time_d;
    if (res_we) begin
      res_q <= res_d;
    end
  end

  // Update valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (inval_we && stale[i]) begin
          valid_q[i] <= 1'b0;
        end else if (fill_we && (fill_idx == IdxW'(i))) begin
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  // Update tags, pages and reference times
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fill_we && (fill_idx == IdxW'(i))) begin
        vpn_q[i]      <= fill_item.vpn;
        ppn_q[i]      <= fill_item.ppn;
        last_use_q[i] <= fill_item.now;
      end else if (touch_we && match[i]) begin
        last_use_q[i] <= q_item_i.now;
      end
    end
  end

endmodule

// ===== sv/fully_associative_tlb_lru.sv =====
// Fully associative TLB with least-recently-used replacement by last-reference time.
// Words enter through a push/full queue and results leave through an empty/pop queue,
// one result per word, in order. A two-word command queue decouples the decoding front
// from the back part that holds the entries. Lookup, invalidate, unused codes and fills
// that find a free entry finish without leaving the idle state; a fill into a full buffer
// scans the reference times one entry per cycle, then writes the oldest entry once the
// result register is free. The back part takes a word only while idle with the result
// register free or popped. No clearing pass after reset: all entries start invalid.
// Depends on fatlb_pkg, fatlb_front and fatlb_back.
module fully_associative_tlb_lru (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [fatlb_pkg::FuncW-1:0]   func_i,
  input  logic [fatlb_pkg::DataW-1:0]   vpn_i,
  input  logic [fatlb_pkg::DataW-1:0]   ppn_i,
  input  logic [fatlb_pkg::DataW-1:0]   now_cycle_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          hit_o,
  output logic [fatlb_pkg::DataW-1:0]   ppn_out_o,
  output logic [fatlb_pkg::SlotW-1:0]   slot_o
);
  import fatlb_pkg::*;

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  fatlb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .vpn_i       (vpn_i),
    .ppn_i       (ppn_i),
    .now_cycle_i (now_cycle_i),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_item_o    (q_item)
  );

  fatlb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_item_i  (q_item),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res)
  );

  // Split the result word onto its ports
  assign hit_o     = res.hit;
  assign ppn_out_o = res.ppn;
  assign slot_o    = res.slot;

endmodule

// ===== tb/sv/fully_associative_tlb_lru_tb.sv =====
// Self-checking testbench for the fully associative TLB with LRU replacement.
// Depends on fatlb_pkg and fully_associative_tlb_lru; predicts each result word in SV.
module fully_associative_tlb_lru_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fatlb_pkg::*;

  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned VPN_POOL = 24;
  localparam int unsigned PPN_POOL = 12;

  // One command word as presented on the input ports
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [DataW-1:0] vpn;
    logic [DataW-1:0] ppn;
    logic [DataW-1:0] now;
  } cmd_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [FuncW-1:0] func_i = '0;
  logic [DataW-1:0] vpn_i = '0;
  logic [DataW-1:0] ppn_i = '0;
  logic [DataW-1:0] now_cycle_i = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic             hit_o;
  logic [DataW-1:0] ppn_out_o;
  logic [SlotW-1:0] slot_o;

  // Predicted TLB contents
  logic             tlb_valid [ENTRIES];
  logic [DataW-1:0] tlb_vpn   [ENTRIES];
  logic [DataW-1:0] tlb_ppn   [ENTRIES];
  logic [DataW-1:0] tlb_stamp [ENTRIES];

  cmd_t      pending_words[$];
  result_t   expected_results[$];
  logic      in_taken = 1'b0;
  int unsigned words_taken = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned total_words = 0;

  fully_associative_tlb_lru dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .vpn_i      (vpn_i),
    .ppn_i      (ppn_i),
    .now_cycle_i(now_cycle_i),
    .empty      (empty),
    .pop        (pop),
    .hit_o      (hit_o),
    .ppn_out_o  (ppn_out_o),
    .slot_o     (slot_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one command word to the predicted contents and return its result
  function automatic result_t translate_word(cmd_t w);
    result_t r;
    bit      found;
    int      victim;
    r = '0;
    found = 1'b0;
    victim = -1;
    case (w.func)
      FUNC_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tlb_valid[i] && tlb_vpn[i] == w.vpn) begin
            if (!found) begin
              found = 1'b1;
              r.ppn = tlb_ppn[i];
              r.slot = SlotW'(i);
            end
            tlb_stamp[i] = w.now;
          end
        end
        r.hit = found;
      end
      FUNC_FILL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (victim < 0 && !tlb_valid[i]) victim = i;
        end
        // no free entry: oldest reference wins, ties to the lowest index
        if (victim < 0) begin
          victim = 0;
          for (int i = 1; i < ENTRIES; i++) begin
            if (tlb_stamp[i] < tlb_stamp[victim]) victim = i;
          end
        end
        tlb_valid[victim] = 1'b1;
        tlb_vpn[victim] = w.vpn;
        tlb_ppn[victim] = w.ppn;
        tlb_stamp[victim] = w.now;
        r.slot = SlotW'(victim);
      end
      FUNC_INVAL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tlb_ppn[i] == w.ppn) tlb_valid[i] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DataW-1:0] want, logic [DataW-1:0] got);
    $display("mismatch %s: expected %h got %h at result %0d", what, want, got, results_seen);
    mismatches++;
  endtask

  task automatic add_word(logic [FuncW-1:0] func, logic [DataW-1:0] vpn,
                          logic [DataW-1:0] ppn, logic [DataW-1:0] now);
    cmd_t w;
    w.func = func;
    w.vpn = vpn;
    w.ppn = ppn;
    w.now = now;
    pending_words.push_back(w);
    total_words++;
  endtask

  // Drive input words; hold a word until it is taken
  always @(negedge clk_i) begin : drive_words
    cmd_t w;
    bit   may_idle;
    if (rst_ni && (!push || in_taken)) begin
      may_idle = !(words_taken >= 150 && words_taken < 280);
      if (pending_words.size() != 0 && !(may_idle && $urandom_range(0, 99) < 9)) begin
        w = pending_words.pop_front();
        push <= 1'b1;
        func_i <= w.func;
        vpn_i <= w.vpn;
        ppn_i <= w.ppn;
        now_cycle_i <= w.now;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Drive pop with random stalls, none inside a quiet window
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_seen >= 150 && results_seen < 280) pop <= 1'b1;
      else pop <= ($urandom_range(0, 99) >= 9);
    end
  end

  // Check popped results, then predict newly taken words
  always @(posedge clk_i) begin : watch_ports
    result_t want;
    cmd_t    cur;
    if (rst_ni) begin
      in_taken <= push && !full;
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", '0, ppn_out_o);
        end else begin
          want = expected_results.pop_front();
          if (hit_o !== want.hit) report_mismatch("hit", DataW'(want.hit), DataW'(hit_o));
          if (ppn_out_o !== want.ppn) report_mismatch("ppn_out", want.ppn, ppn_out_o);
          if (slot_o !== want.slot) begin
            report_mismatch("slot", DataW'(want.slot), DataW'(slot_o));
          end
        end
      end
      if (push && !full) begin
        cur.func = func_i;
        cur.vpn = vpn_i;
        cur.ppn = ppn_i;
        cur.now = now_cycle_i;
        expected_results.push_back(translate_word(cur));
        words_taken++;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL fully_associative_tlb_lru");
      $finish;
    end
  end

  initial begin : stimulus
    logic [DataW-1:0] vpn_pool [VPN_POOL];
    logic [DataW-1:0] ppn_pool [PPN_POOL];
    logic [DataW-1:0] stamp;
    logic [FuncW-1:0] func;
    logic [DataW-1:0] vpn;
    logic [DataW-1:0] ppn;
    logic [DataW-1:0] now;
    int unsigned      pick;

    for (int i = 0; i < ENTRIES; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_vpn[i] = '0;
      tlb_ppn[i] = '0;
      tlb_stamp[i] = '0;
    end

    // Directed: misses on an empty buffer, extremes, duplicate tags, unused code
    add_word(FUNC_LOOKUP, 32'h0, 32'h0, 32'h0);
    add_word(FUNC_FILL, 32'h0, 32'h0, 32'h0);
    add_word(FUNC_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(FUNC_LOOKUP, 32'h0, 32'h0, 32'h0);
    add_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    add_word(FUNC_FILL, 32'h0, 32'h5555_5555, 32'h1);
    add_word(FUNC_LOOKUP, 32'h0, 32'h0, 32'h2);
    add_word(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(FUNC_INVAL, 32'h0, 32'hFFFF_FFFF, 32'h0);
    add_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    // page zero also matches never-written entries, which stay invalid
    add_word(FUNC_INVAL, 32'h0, 32'h0, 32'h0);
    add_word(FUNC_LOOKUP, 32'h0, 32'h0, 32'h3);
    add_word(FUNC_FILL, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h3);
    // fill the rest with equal stamps, then evict the oldest and break a tie
    for (int i = 0; i < 14; i++) add_word(FUNC_FILL, 32'h100 + i, 32'h200 + i, 32'h8);
    add_word(FUNC_FILL, 32'h300, 32'h400, 32'h9);
    add_word(FUNC_FILL, 32'h301, 32'h401, 32'h9);
    add_word(FUNC_FILL, 32'h302, 32'h402, 32'h9);

    // Random: small tag and page pools so hits, evictions and invalidates recur
    for (int i = 0; i < VPN_POOL; i++) vpn_pool[i] = $urandom;
    for (int i = 0; i < PPN_POOL; i++) ppn_pool[i] = $urandom;
    stamp = 32'h10;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) func = FUNC_LOOKUP;
      else if (pick < 78) func = FUNC_FILL;
      else if (pick < 94) func = FUNC_INVAL;
      else func = FUNC_UNUSED;
      vpn = ($urandom_range(0, 99) < 85) ? vpn_pool[$urandom_range(0, VPN_POOL - 1)] : $urandom;
      ppn = ($urandom_range(0, 99) < 80) ? ppn_pool[$urandom_range(0, PPN_POOL - 1)] : $urandom;
      stamp = stamp + $urandom_range(0, 3);
      now = ($urandom_range(0, 99) < 90) ? stamp : $urandom;
      add_word(func, vpn, ppn, now);
    end

    // Hold reset, then release away from the rising edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all words taken, all results back, then a quiet tail
    while (words_taken < total_words || expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS fully_associative_tlb_lru");
    end else begin
      $display("FAIL fully_associative_tlb_lru");
    end
    $finish;
  end

endmodule
